[rtl/core/pdfc_pkg.sv]
// Package: shared constants and types of the pixel dark/flat calibration block.
`timescale 1ns / 1ps
package pdfc_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_RAW_SCALE  = 3'd0,
    REG_DARK_SCALE = 3'd1,
    REG_RCC_GAIN   = 3'd2,
    REG_OUT_SCALE  = 3'd3,
    REG_REF_TEMP   = 3'd4
  } reg_idx_e;

  localparam logic signed [24:0] SLOPE_SCALE_S     = 25'sd10000000;
  localparam logic signed [14:0] INTERCEPT_SCALE_S = 15'sd10000;
  localparam logic [23:0]        SLOPE_SCALE_U     = 24'd10000000;
  localparam logic [13:0]        INTERCEPT_SCALE_U = 14'd10000;
  // full flat response = SLOPE_SCALE * INTERCEPT_SCALE
  localparam logic signed [42:0] FULL_S            = 43'sd100000000000;
  localparam logic [36:0]        FULL_U            = 37'd100000000000;
  localparam logic [36:0]        FF_MIN_U          = 37'd10000;

  localparam logic [23:0] CNT_MAX = 24'hFFFFFF;

  localparam int unsigned QBITS = 16;   // quotient bits resolved by the divider
  localparam int unsigned WREM  = 120;  // dividend / remainder width
  localparam int unsigned WDEN  = 86;   // doubled divisor width

  // sideband carried along the pipeline
  typedef struct packed {
    logic bad;
    logic fstart;
    logic neg;
    logic sat;
  } sb_t;

endpackage

[rtl/core/pixel_dark_flat_calibration.sv]
// Top level: pipelined dark-subtract and flat-field pixel calibration.
`timescale 1ns / 1ps
// Usage
// - Input channel (in_valid_i / in_ready_o): one pixel request per beat with
//   raw, dark, flat slope/intercept, bad-pixel flag and frame-start flag.
// - Output channel (out_valid_o / out_ready_i): one calibrated pixel per
//   request, in order, with clip flags and per-frame clip totals.
// - Config channel (cfg_valid_i / cfg_ready_o, always ready): writes cfg_data_i
//   to cfg_index_i; the user writes only while the block is idle, unenforced.
// - Pipeline: 25 register stages from input accept to output valid: 7
//   arithmetic, one range check, 16 restoring divider steps, output register.
// - Throughput: one pixel per cycle while the receiver is ready; the divider
//   resolves one quotient bit per stage, so 16 divider stages are in flight.
// - Stall: each stage loads when it is empty or its successor loads, so
//   bubbles squeeze out and a stalled receiver backs the pipe up without
//   losing or duplicating requests; in_ready_o drops only when full.
// - Reset: all stages empty, counters zero, registers at defaults
//   (scales 1, gain 1.0 in Q16.16, temperature 0).
// - Counters clear on a frame-start pixel before that pixel is counted and
//   saturate at all ones.
module pixel_dark_flat_calibration
  import pdfc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] raw_pixel_i,
  input  logic signed [15:0] dark_value_i,
  input  logic signed [15:0] slope_coeff_i,
  input  logic signed [15:0] intercept_coeff_i,
  input  logic               bad_pixel_i,
  input  logic               frame_start_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] cal_pixel_o,
  output logic               overflowed_o,
  output logic               underflowed_o,
  output logic [23:0]        overflow_total_o,
  output logic [23:0]        underflow_total_o
);

  // stage map: 0..6 arithmetic, 7 range check, 8..23 divider, 24 output
  localparam int unsigned NST  = 25;
  localparam int unsigned DIV0 = 7;
  localparam int unsigned OUTS = NST - 1;

  // ---------------- configuration registers ----------------
  logic [15:0]        raw_scale_q, dark_scale_q, out_scale_q;
  logic [31:0]        rcc_gain_q;
  logic signed [10:0] ref_temp_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_scale_q  <= 16'd1;
      dark_scale_q <= 16'd1;
      rcc_gain_q   <= 32'd65536;
      out_scale_q  <= 16'd1;
      ref_temp_q   <= '0;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_RAW_SCALE:  raw_scale_q  <= cfg_data_i[15:0];
        REG_DARK_SCALE: dark_scale_q <= cfg_data_i[15:0];
        REG_RCC_GAIN:   rcc_gain_q   <= cfg_data_i;
        REG_OUT_SCALE:  out_scale_q  <= cfg_data_i[15:0];
        REG_REF_TEMP:   ref_temp_q   <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // a scale of zero acts as one
  logic [15:0] rs, ds, os;
  assign rs = (raw_scale_q  == '0) ? 16'd1 : raw_scale_q;
  assign ds = (dark_scale_q == '0) ? 16'd1 : dark_scale_q;
  assign os = (out_scale_q  == '0) ? 16'd1 : out_scale_q;

  // ---------------- flow control ----------------
  logic [NST-1:0] v_q;
  logic [NST-1:0] en;
  sb_t            sb_q [NST-1];

  always_comb begin
    en[OUTS] = !v_q[OUTS] || out_ready_i;
    for (int i = OUTS - 1; i >= 0; i--) begin
      en[i] = !v_q[i] || en[i+1];
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = v_q[OUTS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int i = 1; i < NST; i++) begin
        if (en[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  // ---------------- stage 0: products of inputs ----------------
  logic signed [33:0] diff_q;
  logic signed [26:0] st_q;
  logic signed [40:0] ic_q;
  logic [31:0]        rsds_q;
  logic signed [16:0] rs_s, ds_s;

  assign rs_s = $signed({1'b0, rs});
  assign ds_s = $signed({1'b0, ds});

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      diff_q    <= raw_pixel_i * ds_s - dark_value_i * rs_s;
      st_q      <= slope_coeff_i * ref_temp_q;
      ic_q      <= intercept_coeff_i * SLOPE_SCALE_S;
      rsds_q    <= rs * ds;
      sb_q[0]   <= '{bad: bad_pixel_i, fstart: frame_start_i, neg: 1'b0, sat: 1'b0};
    end
  end

  // ---------------- stage 1: flat response, magnitude ----------------
  logic signed [42:0] ffu;
  logic [36:0]        ffc_d, ffc_q;
  logic [33:0]        ndiff;
  logic [31:0]        mag_q;
  logic [31:0]        rsds1_q;

  always_comb begin
    ffu = st_q * INTERCEPT_SCALE_S + ic_q;
    if (ffu > FULL_S)          ffc_d = FULL_U;
    else if (ffu <= 43'sd0)    ffc_d = FF_MIN_U;
    else                       ffc_d = ffu[36:0];
    ndiff = -diff_q;
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      ffc_q      <= ffc_d;
      mag_q      <= diff_q[33] ? ndiff[31:0] : diff_q[31:0];
      rsds1_q    <= rsds_q;
      sb_q[1]    <= '{bad: sb_q[0].bad, fstart: sb_q[0].fstart, neg: diff_q[33],
                      sat: 1'b0};
    end
  end

  // ---------------- stages 2..5: numerator and denominator ----------------
  logic [63:0]  n1_q;
  logic [79:0]  n2_q;
  logic [103:0] n3_q;
  logic [117:0] n4_q;
  logic [68:0]  d2_q, d3_q, d4_q, d5_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      n1_q    <= mag_q * rcc_gain_q;
      d2_q    <= ffc_q * rsds1_q;
      sb_q[2] <= sb_q[1];
    end
    if (en[3]) begin
      n2_q    <= n1_q * os;
      d3_q    <= d2_q;
      sb_q[3] <= sb_q[2];
    end
    if (en[4]) begin
      n3_q    <= n2_q * SLOPE_SCALE_U;
      d4_q    <= d3_q;
      sb_q[4] <= sb_q[3];
    end
    if (en[5]) begin
      n4_q    <= n3_q * INTERCEPT_SCALE_U;
      d5_q    <= d4_q;
      sb_q[5] <= sb_q[4];
    end
  end

  // ---------------- stage 6: rounding dividend 2N + D, divisor 2D ----------------
  logic [WREM-1:0] tgt_q;
  logic [WDEN-1:0] twod6_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      tgt_q   <= {1'b0, n4_q, 1'b0} + {35'b0, d5_q, 16'b0};
      twod6_q <= {d5_q, 17'b0};
      sb_q[6] <= sb_q[5];
    end
  end

  // ---------------- stage 7: range check, divider entry ----------------
  logic [WREM-1:0]  rem_q  [QBITS+1];
  logic [QBITS-1:0] quo_q  [QBITS+1];
  logic [WDEN-1:0]  twod_q [QBITS+1];

  always_ff @(posedge clk_i) begin
    if (en[DIV0]) begin
      rem_q[0]       <= tgt_q;
      quo_q[0]       <= '0;
      twod_q[0]      <= twod6_q;
      // quotient would need more than QBITS bits: result clips
      sb_q[DIV0]     <= '{bad: sb_q[6].bad, fstart: sb_q[6].fstart, neg: sb_q[6].neg,
                          sat: tgt_q >= {18'b0, twod6_q, 16'b0}};
    end
  end

  // ---------------- restoring divider, one bit per stage ----------------
  for (genvar k = 0; k < QBITS; k++) begin : g_div
    localparam int unsigned B = QBITS - 1 - k;
    logic [WREM-1:0] sh;
    logic            ge;
    assign sh = WREM'(twod_q[k]) << B;
    assign ge = rem_q[k] >= sh;

    always_ff @(posedge clk_i) begin
      if (en[DIV0+1+k]) begin
        rem_q[k+1]     <= ge ? rem_q[k] - sh : rem_q[k];
        quo_q[k+1]     <= quo_q[k] | (QBITS'(ge) << B);
        twod_q[k+1]    <= twod_q[k];
        sb_q[DIV0+1+k] <= sb_q[DIV0+k];
      end
    end
  end

  // ---------------- output stage: saturate, flag, count ----------------
  sb_t              fin;
  logic [QBITS-1:0] q;
  logic             ovf, unf;
  logic [15:0]      pix;
  logic [23:0]      ocnt_base, ucnt_base;
  logic [23:0]      ocnt_q, ucnt_q;
  logic [23:0]      ocnt_d, ucnt_d;
  logic signed [15:0] cal_q;
  logic             ovf_q, unf_q;

  always_comb begin
    fin = sb_q[OUTS-1];
    q   = quo_q[QBITS];
    ovf = !fin.bad && !fin.neg && (fin.sat || q > 16'd32767);
    unf = !fin.bad &&  fin.neg && (fin.sat || q > 16'd32768);
    if (fin.bad)      pix = '0;
    else if (ovf)     pix = 16'h7FFF;
    else if (unf)     pix = 16'h8000;
    else if (fin.neg) pix = -q;
    else              pix = q;
    ocnt_base = fin.fstart ? '0 : ocnt_q;
    ucnt_base = fin.fstart ? '0 : ucnt_q;
    ocnt_d = (ovf && ocnt_base != CNT_MAX) ? ocnt_base + 24'd1 : ocnt_base;
    ucnt_d = (unf && ucnt_base != CNT_MAX) ? ucnt_base + 24'd1 : ucnt_base;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocnt_q <= '0;
      ucnt_q <= '0;
    end else if (en[OUTS] && v_q[OUTS-1]) begin
      ocnt_q <= ocnt_d;
      ucnt_q <= ucnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[OUTS]) begin
      cal_q <= pix;
      ovf_q <= ovf;
      unf_q <= unf;
    end
  end

  assign cal_pixel_o       = cal_q;
  assign overflowed_o      = ovf_q;
  assign underflowed_o     = unf_q;
  assign overflow_total_o  = ocnt_q;
  assign underflow_total_o = ucnt_q;

`ifndef ASSERT_OFF
  a_clip_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(overflowed_o && underflowed_o))
    else $error("both clip flags set");

  a_ovf_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && overflowed_o |-> overflow_total_o != 24'd0)
    else $error("overflow not counted");

  a_unf_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && underflowed_o |-> underflow_total_o != 24'd0)
    else $error("underflow not counted");

  a_ff_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[1] |-> (ffc_q != 37'd0) && (ffc_q <= FULL_U))
    else $error("flat response out of range");

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> v_q[0] && out_valid_o && !out_ready_i)
    else $error("input stalled with room in pipeline");
`endif

endmodule

[sim/pdfc_checker.sv]
// Checker: predicts calibrated pixels from accepted requests and compares results.
`timescale 1ns / 1ps
module pdfc_checker
  import pdfc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [15:0] raw_pixel_i,
  input  logic signed [15:0] dark_value_i,
  input  logic signed [15:0] slope_coeff_i,
  input  logic signed [15:0] intercept_coeff_i,
  input  logic               bad_pixel_i,
  input  logic               frame_start_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [15:0] cal_pixel_i,
  input  logic               overflowed_i,
  input  logic               underflowed_i,
  input  logic [23:0]        overflow_total_i,
  input  logic [23:0]        underflow_total_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic signed [15:0] pix;
    logic               ovf;
    logic               unf;
    logic [23:0]        ovf_total;
    logic [23:0]        unf_total;
  } cal_result_t;

  cal_result_t       cal_q[$];
  logic [15:0]       raw_div, dark_div, out_mul;
  logic [31:0]       gain;
  logic signed [10:0] temp;
  logic [23:0]       ovf_cnt, unf_cnt;

  assign pending_o = cal_q.size();

  // Exact integer calibration of one pixel; updates the clip counters.
  function automatic cal_result_t calibrate(logic signed [15:0] raw, logic signed [15:0] dark,
                                            logic signed [15:0] slope,
                                            logic signed [15:0] icpt, logic bad);
    cal_result_t r;
    longint      rs, ds, os, ffu, diff;
    logic [63:0] mag;
    logic [129:0] num, den, q;
    logic        neg;
    r = '0;
    if (!bad) begin
      rs = (raw_div == 0) ? 1 : longint'(raw_div);
      ds = (dark_div == 0) ? 1 : longint'(dark_div);
      os = (out_mul == 0) ? 1 : longint'(out_mul);
      ffu = longint'(slope) * longint'(temp) * 10000 + longint'(icpt) * 10000000;
      if (ffu > 64'sd100000000000) ffu = 64'sd100000000000;
      if (ffu <= 0) ffu = 10000;
      diff = longint'(raw) * ds - longint'(dark) * rs;
      neg = diff < 0;
      mag = neg ? -diff : diff;
      num = 130'(mag) * 130'(gain) * 130'(os) * 130'(64'd100000000000);
      den = 130'(ffu) * 130'(rs) * 130'(ds) * 130'(65536);
      // round half away from zero on the magnitude
      q = (2 * num + den) / (2 * den);
      if (!neg && q > 32767) begin
        r.pix = 16'sh7FFF;
        r.ovf = 1'b1;
        if (ovf_cnt != CNT_MAX) ovf_cnt++;
      end else if (neg && q > 32768) begin
        r.pix = 16'sh8000;
        r.unf = 1'b1;
        if (unf_cnt != CNT_MAX) unf_cnt++;
      end else begin
        r.pix = neg ? -q[15:0] : q[15:0];
      end
    end
    r.ovf_total = ovf_cnt;
    r.unf_total = unf_cnt;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cal_result_t want;
    if (!rst_ni) begin
      raw_div  = 16'd1;
      dark_div = 16'd1;
      gain     = 32'd65536;
      out_mul  = 16'd1;
      temp     = '0;
      ovf_cnt  = '0;
      unf_cnt  = '0;
      cal_q.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_RAW_SCALE:  raw_div  = cfg_data_i[15:0];
          REG_DARK_SCALE: dark_div = cfg_data_i[15:0];
          REG_RCC_GAIN:   gain     = cfg_data_i;
          REG_OUT_SCALE:  out_mul  = cfg_data_i[15:0];
          REG_REF_TEMP:   temp     = cfg_data_i[10:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        if (frame_start_i) begin
          ovf_cnt = '0;
          unf_cnt = '0;
        end
        cal_q.push_back(calibrate(raw_pixel_i, dark_value_i, slope_coeff_i,
                                  intercept_coeff_i, bad_pixel_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (cal_q.size() == 0) begin
          $error("unexpected result: cal_pixel %0d", cal_pixel_i);
          fail_count_o++;
        end else begin
          want = cal_q.pop_front();
          if (cal_pixel_i !== want.pix) begin
            $error("cal_pixel expected %0d actual %0d", want.pix, cal_pixel_i);
            fail_count_o++;
          end
          if (overflowed_i !== want.ovf) begin
            $error("overflowed expected %0b actual %0b", want.ovf, overflowed_i);
            fail_count_o++;
          end
          if (underflowed_i !== want.unf) begin
            $error("underflowed expected %0b actual %0b", want.unf, underflowed_i);
            fail_count_o++;
          end
          if (overflow_total_i !== want.ovf_total) begin
            $error("overflow_total expected %0d actual %0d", want.ovf_total,
                   overflow_total_i);
            fail_count_o++;
          end
          if (underflow_total_i !== want.unf_total) begin
            $error("underflow_total expected %0d actual %0d", want.unf_total,
                   underflow_total_i);
            fail_count_o++;
          end
        end
      end
    end
  end

endmodule

[sim/tb_top.sv]
// Testbench top: stimulus, idling phases, watchdog and verdict for the calibration block.
`timescale 1ns / 1ps
module tb_top;
  import pdfc_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;  // cycles without any accepted request
  localparam int ITEMS_PER_PHASE = 250;
  localparam int NUM_PHASES = 8;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [31:0]        cfg_data_i = '0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] raw_pixel_i = '0;
  logic signed [15:0] dark_value_i = '0;
  logic signed [15:0] slope_coeff_i = '0;
  logic signed [15:0] intercept_coeff_i = '0;
  logic               bad_pixel_i = 1'b0;
  logic               frame_start_i = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [15:0] cal_pixel_o;
  logic               overflowed_o;
  logic               underflowed_o;
  logic [23:0]        overflow_total_o;
  logic [23:0]        underflow_total_o;

  int fail_count;
  int pending;
  int send_idle_pct;   // chance per request of a sender gap
  int stall_pct;       // chance per cycle of the receiver holding off
  int quiet_cycles = 0;

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  pixel_dark_flat_calibration uut (.*);

  pdfc_checker checker_i (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o),
    .raw_pixel_i, .dark_value_i, .slope_coeff_i, .intercept_coeff_i,
    .bad_pixel_i, .frame_start_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .cal_pixel_i(cal_pixel_o), .overflowed_i(overflowed_o), .underflowed_i(underflowed_o),
    .overflow_total_i(overflow_total_o), .underflow_total_i(underflow_total_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Receiver: random backpressure, redrawn each cycle
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog: any accepted request on either data channel restarts the count
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(negedge clk_i); while (!cfg_ready_o);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_config(logic [15:0] rs, logic [15:0] ds, logic [31:0] gain,
                             logic [15:0] os, logic [31:0] temp);
    write_reg(REG_RAW_SCALE, {16'($urandom_range(65535)), rs});  // upper bits are don't care
    write_reg(REG_DARK_SCALE, {16'd0, ds});
    write_reg(REG_RCC_GAIN, gain);
    write_reg(REG_OUT_SCALE, {16'd0, os});
    write_reg(REG_REF_TEMP, temp);
  endtask

  // Wait until every predicted pixel has come back
  task automatic drain();
    while (pending != 0) @(posedge clk_i);
  endtask

  // One pixel request; optional sender gap first
  task automatic send_pixel(logic signed [15:0] raw, logic signed [15:0] dark,
                            logic signed [15:0] slope, logic signed [15:0] icpt,
                            logic bad, logic fstart);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i        <= 1'b1;
    raw_pixel_i       <= raw;
    dark_value_i      <= dark;
    slope_coeff_i     <= slope;
    intercept_coeff_i <= icpt;
    bad_pixel_i       <= bad;
    frame_start_i     <= fstart;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
  endtask

  task automatic send_random();
    logic signed [15:0] slope, icpt;
    // mostly moderate flat lines so results land inside the range, some full-scale
    case ($urandom_range(3))
      0: begin slope = 16'($urandom); icpt = 16'($urandom); end
      1: begin
        slope = 16'($urandom_range(400) - 200);
        icpt  = 16'($urandom_range(12000));
      end
      2: begin
        slope = 16'($urandom_range(40) - 20);
        icpt  = 16'($urandom_range(300) - 100);
      end
      default: begin slope = 16'($urandom); icpt = 16'($urandom_range(10000, 32767)); end
    endcase
    send_pixel(16'($urandom), 16'($urandom), slope, icpt, $urandom_range(99) < 10,
               $urandom_range(99) < 4);
  endtask

  initial begin
    stall_pct = 0;
    send_idle_pct = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: field extremes, flat clamps, bad pixel and frame start
    load_config(16'd1, 16'd1, 32'd65536, 16'd1, 32'd500);
    send_pixel(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b1);  // flat above one
    send_pixel(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, 1'b0);
    send_pixel(16'sh7FFF, 16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 1'b0);  // zero flat
    send_pixel(16'sh8000, 16'sh0000, 16'sh8000, 16'sh8000, 1'b0, 1'b0);  // negative flat
    send_pixel(16'sd100, 16'sd40, 16'sd0, 16'sd10000, 1'b0, 1'b0);       // unity flat
    send_pixel(-16'sd100, 16'sd40, 16'sd0, 16'sd10000, 1'b0, 1'b0);
    send_pixel(16'sd3, 16'sd2, 16'sd0, 16'sd20000, 1'b0, 1'b0);          // flat clamped to one
    send_pixel(-16'sd3, -16'sd2, 16'sd0, 16'sd20000, 1'b0, 1'b0);
    send_pixel(16'sh7FFF, 16'sh8000, 16'sd0, 16'sd1, 1'b1, 1'b0);        // bad pixel
    send_pixel(16'sd5, 16'sd5, 16'sd7, 16'sd9, 1'b0, 1'b0);              // no signal
    send_pixel(16'sd1000, 16'sd0, 16'sd0, 16'sd1, 1'b0, 1'b1);           // new frame, clip
    send_pixel(-16'sd1000, 16'sd0, 16'sd0, 16'sd1, 1'b0, 1'b0);
    send_pixel(16'sd32767, 16'sd0, 16'sd0, 16'sd10000, 1'b0, 1'b0);      // exactly max
    send_pixel(-16'sd32768, 16'sd0, 16'sd0, 16'sd10000, 1'b0, 1'b0);     // exactly min
    send_pixel(16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA, 1'b0, 1'b1);
    send_pixel(16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555, 1'b1, 1'b1);
    in_valid_i <= 1'b0;
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: load_config(16'd1, 16'd1, 32'd65536, 16'd1, 32'd0);
        1: load_config(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 32'd1000);
        2: load_config(16'd1, 16'd1, 32'd1, 16'd1, -32'sd1000);
        3: load_config(16'd0, 16'd0, 32'd0, 16'd0, 32'h400);     // zero scales and gain
        4: load_config(16'd0, 16'd7, 32'd131072, 16'd0, 32'h3FF);  // largest positive temperature
        default: load_config(16'($urandom_range(1, 300)), 16'($urandom_range(1, 300)),
                             $urandom, 16'($urandom_range(1, 40)),
                             32'($urandom_range(2000)) - 32'd1000);
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 53; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 53; end
        default: begin send_idle_pct = 30; stall_pct = 30; end
      endcase
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == 3 && i == ITEMS_PER_PHASE / 2) begin
          // sender holds off until the pipe has emptied
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          drain();
        end
        send_random();
      end
      in_valid_i <= 1'b0;
      drain();
    end

    stall_pct = 0;
    repeat (40) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
